// ===== sv/ut2cal_pkg.sv =====
`default_nettype none
package ut2cal_pkg;

  // seconds from 1970-01-01 to 2000-01-01
  localparam logic [31:0] EPOCH_2000 = 32'd946684800;

  // reciprocal of 60, exact with a shift of 37 for any 32-bit dividend
  localparam logic [31:0] RECIP_60 = 32'h88888889;
  localparam int          SHIFT_60 = 37;

  // reciprocal of 3, exact with a shift of 19 for any 18-bit dividend
  localparam logic [17:0] RECIP_3 = 18'h2AAAB;
  localparam int          SHIFT_3 = 19;

  // reciprocal of 1461 (days in four years), exact with a shift of 27 below 2^16
  localparam logic [16:0] RECIP_1461 = 17'd91868;
  localparam int          SHIFT_1461 = 27;

  localparam logic [10:0] DAYS_PER_QUAD = 11'd1461;

  // first day of each year within a four-year group, leap year first
  localparam logic [10:0] YEAR1_START = 11'd366;
  localparam logic [10:0] YEAR2_START = 11'd731;
  localparam logic [10:0] YEAR3_START = 11'd1096;

  // day of year on which month index m (0 is January) starts
  function automatic logic [8:0] month_start(input logic [3:0] m, input logic leap);
    logic [8:0] base;
    case (m)
      4'd0:    base = 9'd0;
      4'd1:    base = 9'd31;
      4'd2:    base = 9'd59;
      4'd3:    base = 9'd90;
      4'd4:    base = 9'd120;
      4'd5:    base = 9'd151;
      4'd6:    base = 9'd181;
      4'd7:    base = 9'd212;
      4'd8:    base = 9'd243;
      4'd9:    base = 9'd273;
      4'd10:   base = 9'd304;
      4'd11:   base = 9'd334;
      default: base = 9'd0;
    endcase
    // february lengthened in leap years shifts march onward
    if (leap && (m >= 4'd2)) begin
      base = base + 9'd1;
    end
    return base;
  endfunction

endpackage
`default_nettype wire

// ===== sv/unix_time_to_calendar.sv =====
// Unix timestamp to calendar breakdown: second, minute, hour, years since 2000,
// month and day of month. Timestamps before 2000 wrap modulo 2^32, and every
// fourth year is leap, so dates are exact from 2000 through February 2100.
// Fully pipelined over 11 register stages: one transaction is accepted each
// cycle unless a result waits on out_ready. The divisions by 60, 60, 24
// and by the four-year length are reciprocal multiplications, each followed
// by a register, and these multiplier stages set the depth. When the output
// transaction is held by out_ready low, the whole pipeline freezes and
// in_ready drops; nothing is lost or repeated.
`default_nettype none
module unix_time_to_calendar
  import ut2cal_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [31:0] unix_seconds,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [5:0]       second,
  output logic [5:0]       minute,
  output logic [4:0]       hour,
  output logic [7:0]       year_since_2000,
  output logic [3:0]       month,
  output logic [4:0]       day_of_month
);

  logic        en;
  logic        tod_valid;
  logic [5:0]  tod_second;
  logic [5:0]  tod_minute;
  logic [4:0]  tod_hour;
  logic [15:0] tod_days;

  // pipeline advances unless a finished result is waiting
  assign en       = !out_valid || out_ready;
  assign in_ready = en;

  // time of day and whole days since 2000
  ut2cal_tod u_tod (
    .clk          (clk),
    .rst          (rst),
    .en           (en),
    .in_valid     (in_valid),
    .unix_seconds (unix_seconds),
    .out_valid    (tod_valid),
    .second       (tod_second),
    .minute       (tod_minute),
    .hour         (tod_hour),
    .days         (tod_days)
  );

  // year, month and day from the day count
  ut2cal_date u_date (
    .clk             (clk),
    .rst             (rst),
    .en              (en),
    .in_valid        (tod_valid),
    .in_second       (tod_second),
    .in_minute       (tod_minute),
    .in_hour         (tod_hour),
    .in_days         (tod_days),
    .out_valid       (out_valid),
    .second          (second),
    .minute          (minute),
    .hour            (hour),
    .year_since_2000 (year_since_2000),
    .month           (month),
    .day_of_month    (day_of_month)
  );

endmodule
`default_nettype wire

// ===== sv/ut2cal_tod.sv =====
`default_nettype none
module ut2cal_tod
  import ut2cal_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        en,
  input  wire logic        in_valid,
  input  wire logic [31:0] unix_seconds,
  output logic             out_valid,
  output logic [5:0]       second,
  output logic [5:0]       minute,
  output logic [4:0]       hour,
  output logic [15:0]      days
);

  // valid bits for the seven stages
  logic [6:0] vld;

  logic [31:0] t1;
  logic [31:0] t2;
  logic [63:0] p1;
  logic [5:0]  sec3;
  logic [26:0] q1_3;
  logic [5:0]  sec4;
  logic [26:0] q1_4;
  logic [58:0] p2;
  logic [5:0]  sec5;
  logic [5:0]  min5;
  logic [20:0] q2_5;
  logic [5:0]  sec6;
  logic [5:0]  min6;
  logic [20:0] q2_6;
  logic [35:0] p3;

  logic [26:0] q1_next;
  logic [31:0] sec_full;
  logic [20:0] q2_next;
  logic [26:0] min_full;
  logic [15:0] days_next;
  logic [20:0] hr_full;

  // quotient by 60 and remainder, seconds
  assign q1_next  = p1[SHIFT_60 +: 27];
  assign sec_full = t2 - (({5'd0, q1_next} << 6) - ({5'd0, q1_next} << 2));

  // quotient by 60 and remainder, minutes
  assign q2_next  = p2[SHIFT_60 +: 21];
  assign min_full = q1_4 - (({6'd0, q2_next} << 6) - ({6'd0, q2_next} << 2));

  // quotient by 24 and remainder, hours
  assign days_next = p3[SHIFT_3 +: 16];
  assign hr_full   = q2_6 - (({5'd0, days_next} << 4) + ({5'd0, days_next} << 3));

  // valid chain
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[5:0], in_valid};
    end
  end

  // data stages
  always_ff @(posedge clk) begin
    if (en) begin
      t1     <= unix_seconds - EPOCH_2000;
      t2     <= t1;
      p1     <= t1 * RECIP_60;
      sec3   <= sec_full[5:0];
      q1_3   <= q1_next;
      sec4   <= sec3;
      q1_4   <= q1_3;
      p2     <= q1_3 * RECIP_60;
      sec5   <= sec4;
      min5   <= min_full[5:0];
      q2_5   <= q2_next;
      sec6   <= sec5;
      min6   <= min5;
      q2_6   <= q2_5;
      p3     <= q2_5[20:3] * RECIP_3;
      second <= sec6;
      minute <= min6;
      hour   <= hr_full[4:0];
      days   <= days_next;
    end
  end

  assign out_valid = vld[6];

endmodule
`default_nettype wire

// ===== sv/ut2cal_date.sv =====
`default_nettype none
module ut2cal_date
  import ut2cal_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        en,
  input  wire logic        in_valid,
  input  wire logic [5:0]  in_second,
  input  wire logic [5:0]  in_minute,
  input  wire logic [4:0]  in_hour,
  input  wire logic [15:0] in_days,
  output logic             out_valid,
  output logic [5:0]       second,
  output logic [5:0]       minute,
  output logic [4:0]       hour,
  output logic [7:0]       year_since_2000,
  output logic [3:0]       month,
  output logic [4:0]       day_of_month
);

  // valid bits for the four stages
  logic [3:0] vld;

  logic [5:0]  sec_a, sec_b, sec_c;
  logic [5:0]  min_a, min_b, min_c;
  logic [4:0]  hr_a, hr_b, hr_c;
  logic [15:0] days_a;
  logic [32:0] p4;
  logic [5:0]  quad_b;
  logic [10:0] r_b;
  logic [7:0]  year_c;
  logic [8:0]  doy_c;
  logic        leap_c;

  logic [5:0]  quad_next;
  logic [15:0] r_full;
  logic [1:0]  yq;
  logic [10:0] ystart;
  logic [10:0] doy_full;
  logic [3:0]  mon_idx;
  logic [8:0]  dom_full;

  // four-year groups and the day within the group
  assign quad_next = p4[SHIFT_1461 +: 6];
  assign r_full    = days_a - ({10'd0, quad_next} * {5'd0, DAYS_PER_QUAD});

  // year within the group, the first one being leap
  always_comb begin
    if (r_b < YEAR1_START) begin
      yq     = 2'd0;
      ystart = 11'd0;
    end else if (r_b < YEAR2_START) begin
      yq     = 2'd1;
      ystart = YEAR1_START;
    end else if (r_b < YEAR3_START) begin
      yq     = 2'd2;
      ystart = YEAR2_START;
    end else begin
      yq     = 2'd3;
      ystart = YEAR3_START;
    end
  end
  assign doy_full = r_b - ystart;

  // month from parallel compares against month starts
  always_comb begin
    mon_idx = 4'd0;
    for (int m = 1; m < 12; m++) begin
      if (doy_c >= month_start(4'(m), leap_c)) begin
        mon_idx = 4'(m);
      end
    end
  end
  assign dom_full = doy_c - month_start(mon_idx, leap_c) + 9'd1;

  // valid chain
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[2:0], in_valid};
    end
  end

  // data stages
  always_ff @(posedge clk) begin
    if (en) begin
      sec_a           <= in_second;
      min_a           <= in_minute;
      hr_a            <= in_hour;
      days_a          <= in_days;
      p4              <= in_days * RECIP_1461;
      sec_b           <= sec_a;
      min_b           <= min_a;
      hr_b            <= hr_a;
      quad_b          <= quad_next;
      r_b             <= r_full[10:0];
      sec_c           <= sec_b;
      min_c           <= min_b;
      hr_c            <= hr_b;
      year_c          <= {quad_b, yq};
      doy_c           <= doy_full[8:0];
      leap_c          <= (yq == 2'd0);
      second          <= sec_c;
      minute          <= min_c;
      hour            <= hr_c;
      year_since_2000 <= year_c;
      month           <= mon_idx + 4'd1;
      day_of_month    <= dom_full[4:0];
    end
  end

  assign out_valid = vld[3];

endmodule
`default_nettype wire
